@@ design/cramer_pkg.sv @@
// Shared constants for the 3x3 Cramer solver.
// Holds the Sarrus term layout and the divider step grouping; no dependencies.
`timescale 1ns / 1ps

package cramer_pkg;

   localparam int NUM_DETS  = 4;
   localparam int NUM_TERMS = 6;
   localparam int NUM_SOLS  = 3;

   // quotient bits resolved per divider pipeline stage
   localparam int DIV_BITS_PER_STAGE = 2;

   typedef logic [1:0] idx_type;

   // column used in row 0, 1, 2 for each Sarrus term
   localparam idx_type TERM_COL [NUM_TERMS][3] = '{
      '{2'd0, 2'd1, 2'd2},
      '{2'd1, 2'd2, 2'd0},
      '{2'd2, 2'd0, 2'd1},
      '{2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd2, 2'd1},
      '{2'd1, 2'd0, 2'd2}
   };

   // terms that are subtracted
   localparam logic [NUM_TERMS-1:0] TERM_NEG = 6'b111000;

endpackage

@@ design/cramer_req_if.sv @@
// Request channel of the Cramer solver: one 3x3 system per transaction.
// Stand-alone; width follows the COEF_WIDTH parameter.
`timescale 1ns / 1ps

interface cramer_req_if #(
   parameter int COEF_WIDTH = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coef_r0c0;
   logic signed [COEF_WIDTH-1:0] coef_r0c1;
   logic signed [COEF_WIDTH-1:0] coef_r0c2;
   logic signed [COEF_WIDTH-1:0] coef_r1c0;
   logic signed [COEF_WIDTH-1:0] coef_r1c1;
   logic signed [COEF_WIDTH-1:0] coef_r1c2;
   logic signed [COEF_WIDTH-1:0] coef_r2c0;
   logic signed [COEF_WIDTH-1:0] coef_r2c1;
   logic signed [COEF_WIDTH-1:0] coef_r2c2;
   logic signed [COEF_WIDTH-1:0] rhs_r0;
   logic signed [COEF_WIDTH-1:0] rhs_r1;
   logic signed [COEF_WIDTH-1:0] rhs_r2;

   modport source (
      output valid, coef_r0c0, coef_r0c1, coef_r0c2, coef_r1c0, coef_r1c1, coef_r1c2,
             coef_r2c0, coef_r2c1, coef_r2c2, rhs_r0, rhs_r1, rhs_r2,
      input  ready
   );
   modport sink (
      input  valid, coef_r0c0, coef_r0c1, coef_r0c2, coef_r1c0, coef_r1c1, coef_r1c2,
             coef_r2c0, coef_r2c1, coef_r2c2, rhs_r0, rhs_r1, rhs_r2,
      output ready
   );
endinterface

@@ design/cramer_rsp_if.sv @@
// Response channel of the Cramer solver: solution vector and status flags.
// Stand-alone; width follows the SOL_WIDTH parameter.
`timescale 1ns / 1ps

interface cramer_rsp_if #(
   parameter int SOL_WIDTH = 32
) ();
   logic                        valid;
   logic                        ready;
   logic signed [SOL_WIDTH-1:0] sol_x;
   logic signed [SOL_WIDTH-1:0] sol_y;
   logic signed [SOL_WIDTH-1:0] sol_z;
   logic                        singular;
   logic                        saturated;

   modport source (
      output valid, sol_x, sol_y, sol_z, singular, saturated,
      input  ready
   );
   modport sink (
      input  valid, sol_x, sol_y, sol_z, singular, saturated,
      output ready
   );
endinterface

@@ design/cramer_3x3_linear_solver_unit.sv @@
// Pipelined 3x3 linear solver by Cramer's rule with saturating Q fixed-point output.
// Depends on cramer_pkg, cramer_req_if and cramer_rsp_if.
//
//   channel   direction  transaction content
//   req_bus   in         nine coefficients and three right-hand sides
//   rsp_bus   out        sol_x, sol_y, sol_z, singular, saturated
//
// One transaction per cycle sustained while rsp_bus.ready stays high; the pipeline
// is two multiply stages, one summing stage and one prep stage, then the restoring
// divider resolving two quotient bits per stage.
// reset is synchronous and clears only the stage valid bits.
// Each stage holds while its successor is full and stalled; bubbles are squeezed out.
`timescale 1ns / 1ps

module cramer_3x3_linear_solver_unit
   import cramer_pkg::*;
#(
   parameter int COEF_WIDTH = 16,
   parameter int SOL_WIDTH  = 32
) (
   input  logic         clock,
   input  logic         reset,
   cramer_req_if.sink   req_bus,
   cramer_rsp_if.source rsp_bus
);

   localparam int CW  = COEF_WIDTH;
   localparam int W   = SOL_WIDTH;
   localparam int F   = SOL_WIDTH / 2;
   localparam int SH  = W - F;
   localparam int PW  = 2 * CW;
   localparam int TW  = 3 * CW;
   localparam int DW  = 3 * CW + 3;
   localparam int MW  = DW;
   localparam int NW  = MW + F;
   localparam int BPS = DIV_BITS_PER_STAGE;
   localparam int NDS = (W + BPS - 1) / BPS;
   localparam int NST = NDS + 5;
   localparam int DV0 = 3;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;
   logic [NST:0]   adv;

   logic signed [CW-1:0] mat [NUM_DETS][3][3];
   logic signed [CW-1:0] rhs [3];

   logic signed [PW-1:0] pp_ff  [NUM_DETS][NUM_TERMS];
   logic signed [PW-1:0] pp_in  [NUM_DETS][NUM_TERMS];
   logic signed [CW-1:0] thr_ff [NUM_DETS][NUM_TERMS];
   logic signed [CW-1:0] thr_in [NUM_DETS][NUM_TERMS];
   logic signed [TW-1:0] tp_ff  [NUM_DETS][NUM_TERMS];
   logic signed [TW-1:0] tp_in  [NUM_DETS][NUM_TERMS];
   logic signed [DW-1:0] det_ff [NUM_DETS];
   logic signed [DW-1:0] det_in [NUM_DETS];

   logic [MW-1:0] rem_ff  [NDS+1][NUM_SOLS];
   logic [MW-1:0] rem_in  [NDS+1][NUM_SOLS];
   logic [W-1:0]  shf_ff  [NDS+1][NUM_SOLS];
   logic [W-1:0]  shf_in  [NDS+1][NUM_SOLS];
   logic [W-1:0]  quo_ff  [NDS+1][NUM_SOLS];
   logic [W-1:0]  quo_in  [NDS+1][NUM_SOLS];
   logic          neg_ff  [NDS+1][NUM_SOLS];
   logic          neg_in  [NDS+1][NUM_SOLS];
   logic          ovf_ff  [NDS+1][NUM_SOLS];
   logic          ovf_in  [NDS+1][NUM_SOLS];
   logic [MW-1:0] den_ff  [NDS+1];
   logic [MW-1:0] den_in  [NDS+1];
   logic          sing_ff [NDS+1];
   logic          sing_in [NDS+1];

   logic [W-1:0] sol_ff [NUM_SOLS];
   logic [W-1:0] sol_in [NUM_SOLS];
   logic         out_sing_ff;
   logic         out_sing_in;
   logic         out_sat_ff;
   logic         out_sat_in;

   // stage advance chain
   always_comb begin
      adv[NST] = rsp_bus.ready;
      for (int k = NST - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = req_bus.valid;
      for (int k = 1; k < NST; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_bus.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // build the four matrices: system, then column x, y, z replaced
   always_comb begin
      rhs[0] = req_bus.rhs_r0;
      rhs[1] = req_bus.rhs_r1;
      rhs[2] = req_bus.rhs_r2;
      mat[0][0][0] = req_bus.coef_r0c0;
      mat[0][0][1] = req_bus.coef_r0c1;
      mat[0][0][2] = req_bus.coef_r0c2;
      mat[0][1][0] = req_bus.coef_r1c0;
      mat[0][1][1] = req_bus.coef_r1c1;
      mat[0][1][2] = req_bus.coef_r1c2;
      mat[0][2][0] = req_bus.coef_r2c0;
      mat[0][2][1] = req_bus.coef_r2c1;
      mat[0][2][2] = req_bus.coef_r2c2;
      for (int d = 1; d < NUM_DETS; d++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               mat[d][r][c] = (c == d - 1) ? rhs[r] : mat[0][r][c];
            end
         end
      end
   end

   // products, then Sarrus sums
   always_comb begin
      for (int d = 0; d < NUM_DETS; d++) begin
         det_in[d] = '0;
         for (int t = 0; t < NUM_TERMS; t++) begin
            pp_in[d][t]  = mat[d][0][TERM_COL[t][0]] * mat[d][1][TERM_COL[t][1]];
            thr_in[d][t] = mat[d][2][TERM_COL[t][2]];
            tp_in[d][t]  = pp_ff[d][t] * thr_ff[d][t];
            if (TERM_NEG[t]) begin
               det_in[d] = det_in[d] - DW'(tp_ff[d][t]);
            end else begin
               det_in[d] = det_in[d] + DW'(tp_ff[d][t]);
            end
         end
      end
   end

   // divider setup and restoring steps
   always_comb begin
      logic [MW-1:0]   mag_v [NUM_DETS];
      logic [NW-1:0]   nfull_v;
      logic [MW+SH-1:0] lhs_v;
      logic [MW+SH-1:0] rhs_v;
      logic [MW-1:0]   rem_v;
      logic [W-1:0]    shf_v;
      logic [W-1:0]    quo_v;
      logic [MW:0]     rem2_v;
      logic [MW:0]     diff_v;
      logic            qbit_v;

      for (int d = 0; d < NUM_DETS; d++) begin
         mag_v[d] = det_ff[d][DW-1] ? MW'(-det_ff[d]) : MW'(det_ff[d]);
      end
      den_in[0]  = mag_v[0];
      sing_in[0] = (det_ff[0] == '0);
      for (int k = 0; k < NUM_SOLS; k++) begin
         nfull_v        = {mag_v[k+1], {F{1'b0}}};
         rem_in[0][k]   = MW'(nfull_v[NW-1:W]);
         shf_in[0][k]   = nfull_v[W-1:0];
         quo_in[0][k]   = '0;
         neg_in[0][k]   = det_ff[k+1][DW-1] ^ det_ff[0][DW-1];
         lhs_v          = {{SH{1'b0}}, mag_v[k+1]};
         rhs_v          = {mag_v[0], {SH{1'b0}}};
         ovf_in[0][k]   = (lhs_v >= rhs_v);
      end

      for (int s = 1; s <= NDS; s++) begin
         den_in[s]  = den_ff[s-1];
         sing_in[s] = sing_ff[s-1];
         for (int k = 0; k < NUM_SOLS; k++) begin
            rem_v = rem_ff[s-1][k];
            shf_v = shf_ff[s-1][k];
            quo_v = quo_ff[s-1][k];
            for (int j = 0; j < BPS; j++) begin
               if ((s - 1) * BPS + j < W) begin
                  rem2_v = {rem_v, shf_v[W-1]};
                  diff_v = rem2_v - {1'b0, den_ff[s-1]};
                  qbit_v = (rem2_v >= {1'b0, den_ff[s-1]});
                  rem_v  = qbit_v ? diff_v[MW-1:0] : rem2_v[MW-1:0];
                  shf_v  = {shf_v[W-2:0], 1'b0};
                  quo_v  = {quo_v[W-2:0], qbit_v};
               end
            end
            rem_in[s][k] = rem_v;
            shf_in[s][k] = shf_v;
            quo_in[s][k] = quo_v;
            neg_in[s][k] = neg_ff[s-1][k];
            ovf_in[s][k] = ovf_ff[s-1][k];
         end
      end
   end

   // sign, saturate, singular override
   always_comb begin
      logic [W-1:0] q_v;
      logic         sat_v;

      out_sat_in  = 1'b0;
      out_sing_in = sing_ff[NDS];
      for (int k = 0; k < NUM_SOLS; k++) begin
         q_v = quo_ff[NDS][k];
         if (neg_ff[NDS][k]) begin
            sat_v     = ovf_ff[NDS][k] || (q_v[W-1] && (|q_v[W-2:0]));
            sol_in[k] = sat_v ? {1'b1, {(W-1){1'b0}}} : -q_v;
         end else begin
            sat_v     = ovf_ff[NDS][k] || q_v[W-1];
            sol_in[k] = sat_v ? {1'b0, {(W-1){1'b1}}} : q_v;
         end
         if (sing_ff[NDS]) begin
            sol_in[k] = '0;
            sat_v     = 1'b0;
         end
         out_sat_in = out_sat_in || sat_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pp_ff  <= pp_in;
         thr_ff <= thr_in;
      end
      if (adv[1]) begin
         tp_ff <= tp_in;
      end
      if (adv[2]) begin
         det_ff <= det_in;
      end
      for (int s = 0; s <= NDS; s++) begin
         if (adv[DV0+s]) begin
            rem_ff[s]  <= rem_in[s];
            shf_ff[s]  <= shf_in[s];
            quo_ff[s]  <= quo_in[s];
            neg_ff[s]  <= neg_in[s];
            ovf_ff[s]  <= ovf_in[s];
            den_ff[s]  <= den_in[s];
            sing_ff[s] <= sing_in[s];
         end
      end
      if (adv[NST-1]) begin
         sol_ff      <= sol_in;
         out_sing_ff <= out_sing_in;
         out_sat_ff  <= out_sat_in;
      end
   end

   assign rsp_bus.valid     = v_ff[NST-1];
   assign rsp_bus.sol_x     = sol_ff[0];
   assign rsp_bus.sol_y     = sol_ff[1];
   assign rsp_bus.sol_z     = sol_ff[2];
   assign rsp_bus.singular  = out_sing_ff;
   assign rsp_bus.saturated = out_sat_ff;

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.singular |->
         rsp_bus.sol_x == '0 && rsp_bus.sol_y == '0 && rsp_bus.sol_z == '0 &&
         !rsp_bus.saturated)
      else $error("singular transaction carries nonzero solution");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("input blocked while output stage is empty");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[DV0] && !adv[DV0] |=> v_ff[DV0] && $stable(quo_ff[0][0]))
      else $error("stalled divider stage lost its transaction");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> v_ff[0])
      else $error("accepted transaction missing from first stage");

endmodule

@@ dv/cramer_3x3_linear_solver_unit_test.sv @@
// Self-checking bench for the pipelined 3x3 Cramer solver: directed table, then random systems.
// Depends on cramer_req_if, cramer_rsp_if and cramer_3x3_linear_solver_unit.
`timescale 1ns / 1ps

module cramer_3x3_linear_solver_unit_test;

   localparam int CW = 16;
   localparam int SW = 32;
   localparam int NUM_RANDOM = 1630;

   typedef struct {
      logic signed [CW-1:0] a [3][3];
      logic signed [CW-1:0] b [3];
   } system_type;

   typedef struct {
      logic signed [SW-1:0] x;
      logic signed [SW-1:0] y;
      logic signed [SW-1:0] z;
      logic                 singular;
      logic                 saturated;
   } solution_type;

   typedef struct {
      system_type   sys;
      bit           typed;
      solution_type sol;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count = 0;
   int   sent_count = 0;
   int   recv_count = 0;
   int   singular_count = 0;
   int   clip_count = 0;
   bit   stim_done = 1'b0;

   solution_type expected_q [$];

   cramer_req_if #(.COEF_WIDTH(CW)) req_bus ();
   cramer_rsp_if #(.SOL_WIDTH(SW))  rsp_bus ();

   cramer_3x3_linear_solver_unit #(.COEF_WIDTH(CW), .SOL_WIDTH(SW)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always #10 clock = ~clock;

   function automatic longint det3(longint m [3][3]);
      return m[0][0]*m[1][1]*m[2][2] + m[0][1]*m[1][2]*m[2][0] + m[0][2]*m[1][0]*m[2][1]
           - m[0][2]*m[1][1]*m[2][0] - m[0][0]*m[1][2]*m[2][1] - m[0][1]*m[1][0]*m[2][2];
   endfunction

   function automatic logic [SW-1:0] q16_divide(longint num, longint den, ref logic clip);
      logic [63:0] mag_n, mag_d, q;
      bit neg;
      mag_n = num < 0 ? -num : num;
      mag_d = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      q = (mag_n << 16) / mag_d;
      if (!neg && q > 64'h7fff_ffff) begin
         clip = 1'b1;
         q = 64'h7fff_ffff;
      end else if (neg && q > 64'h8000_0000) begin
         clip = 1'b1;
         q = 64'h8000_0000;
      end
      return neg ? SW'(-q) : SW'(q);
   endfunction

   function automatic solution_type solve_system(system_type s);
      longint a [3][3];
      longint mx [3][3];
      longint my [3][3];
      longint mz [3][3];
      longint d;
      solution_type r;
      logic clip;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            a[i][j] = s.a[i][j];
      mx = a;
      my = a;
      mz = a;
      for (int i = 0; i < 3; i++) begin
         mx[i][0] = s.b[i];
         my[i][1] = s.b[i];
         mz[i][2] = s.b[i];
      end
      d = det3(a);
      r = '{default: '0};
      if (d == 0) begin
         r.singular = 1'b1;
         return r;
      end
      clip = 1'b0;
      r.x = q16_divide(det3(mx), d, clip);
      r.y = q16_divide(det3(my), d, clip);
      r.z = q16_divide(det3(mz), d, clip);
      r.saturated = clip;
      return r;
   endfunction

   function automatic bit same_solution(solution_type p, solution_type q);
      return p.x === q.x && p.y === q.y && p.z === q.z && p.singular === q.singular
          && p.saturated === q.saturated;
   endfunction

   function automatic system_type diag_system(int d0, int d1, int d2, int b0, int b1, int b2);
      system_type s;
      s.a = '{'{CW'(d0), 16'sd0, 16'sd0}, '{16'sd0, CW'(d1), 16'sd0},
              '{16'sd0, 16'sd0, CW'(d2)}};
      s.b = '{CW'(b0), CW'(b1), CW'(b2)};
      return s;
   endfunction

   function automatic system_type fill_system(int v);
      system_type s;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++)
            s.a[i][j] = CW'(v);
         s.b[i] = CW'(v);
      end
      return s;
   endfunction

   function automatic system_type random_system();
      system_type s;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            case (mode)
               0: s.a[i][j] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
               1, 2: s.a[i][j] = CW'($urandom_range(0, 1024)) - 16'sd512;
               3: s.a[i][j] = CW'($urandom_range(0, 6)) - 16'sd3;
               default: s.a[i][j] = CW'($urandom);
            endcase
         end
         s.b[i] = (mode == 0 && $urandom_range(0, 1)) ? 16'sh8000 : CW'($urandom);
      end
      if (mode == 3 && $urandom_range(0, 1)) begin
         s.a[2] = s.a[$urandom_range(0, 1)];
      end else if (mode == 4) begin
         for (int j = 0; j < 3; j++)
            s.a[2][j] = s.a[0][j] + s.a[1][j];
      end
      return s;
   endfunction

   task automatic send_system(system_type s);
      req_bus.valid <= 1'b1;
      req_bus.coef_r0c0 <= s.a[0][0];
      req_bus.coef_r0c1 <= s.a[0][1];
      req_bus.coef_r0c2 <= s.a[0][2];
      req_bus.coef_r1c0 <= s.a[1][0];
      req_bus.coef_r1c1 <= s.a[1][1];
      req_bus.coef_r1c2 <= s.a[1][2];
      req_bus.coef_r2c0 <= s.a[2][0];
      req_bus.coef_r2c1 <= s.a[2][1];
      req_bus.coef_r2c2 <= s.a[2][2];
      req_bus.rhs_r0 <= s.b[0];
      req_bus.rhs_r1 <= s.b[1];
      req_bus.rhs_r2 <= s.b[2];
      do @(posedge clock); while (!req_bus.ready);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic pause_sender(ref int burst_left);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      stim_row_type rows [$];
      system_type s;
      solution_type expect_sol;
      int burst_left;
      req_bus.valid = 1'b0;
      req_bus.coef_r0c0 = '0;
      req_bus.coef_r0c1 = '0;
      req_bus.coef_r0c2 = '0;
      req_bus.coef_r1c0 = '0;
      req_bus.coef_r1c1 = '0;
      req_bus.coef_r1c2 = '0;
      req_bus.coef_r2c0 = '0;
      req_bus.coef_r2c1 = '0;
      req_bus.coef_r2c2 = '0;
      req_bus.rhs_r0 = '0;
      req_bus.rhs_r1 = '0;
      req_bus.rhs_r2 = '0;
      burst_left = 0;

      rows.push_back('{fill_system(0), 1'b1, '{0, 0, 0, 1'b1, 1'b0}});
      rows.push_back('{fill_system(16'h7fff), 1'b1, '{0, 0, 0, 1'b1, 1'b0}});
      rows.push_back('{fill_system(-32768), 1'b1, '{0, 0, 0, 1'b1, 1'b0}});
      rows.push_back('{diag_system(256, 256, 256, 256, 512, -768), 1'b1,
                       '{32'sh1_0000, 32'sh2_0000, -32'sh3_0000, 1'b0, 1'b0}});
      rows.push_back('{diag_system(1, 1, 1, 32767, -32768, 0), 1'b1,
                       '{32'sh7fff_0000, 32'sh8000_0000, 0, 1'b0, 1'b0}});
      rows.push_back('{diag_system(-1, 1, 1, -32768, 1, -1), 1'b1,
                       '{32'sh7fff_ffff, 32'sh1_0000, -32'sh1_0000, 1'b0, 1'b1}});
      rows.push_back('{diag_system(32767, 32767, 32767, 32767, -32767, 0), 1'b1,
                       '{32'sh1_0000, -32'sh1_0000, 0, 1'b0, 1'b0}});
      rows.push_back('{diag_system(-32768, -32768, -32768, -32768, 32767, 1), 0, '{default: 0}});
      rows.push_back('{diag_system(1, -1, 256, 1, 1, 1), 0, '{default: 0}});
      rows.push_back('{diag_system(3, 7, -5, 100, -200, 300), 0, '{default: 0}});
      rows.push_back('{diag_system(16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0),
                       0, '{default: 0}});
      s = diag_system(256, 256, 256, 1, 1, 1);
      s.a[0][1] = 16'sd256;
      s.a[1][2] = -16'sd512;
      s.a[2][0] = 16'sd128;
      rows.push_back('{s, 0, '{default: 0}});
      s.a[2] = s.a[0];
      rows.push_back('{s, 1'b1, '{0, 0, 0, 1'b1, 1'b0}});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         expect_sol = rows[i].typed ? rows[i].sol : solve_system(rows[i].sys);
         if (rows[i].typed && !same_solution(expect_sol, solve_system(rows[i].sys)))
            $error("table row %0d disagrees with predictor", i);
         expected_q.push_back(expect_sol);
         send_system(rows[i].sys);
         pause_sender(burst_left);
      end
      for (int n = 0; n < NUM_RANDOM; n++) begin
         s = random_system();
         expected_q.push_back(solve_system(s));
         send_system(s);
         pause_sender(burst_left);
      end
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      int phase;
      rsp_bus.ready = 1'b0;
      phase = 0;
      @(negedge clock);
      forever begin
         phase++;
         if (phase % 200 < 40)
            rsp_bus.ready <= 1'b1;
         else
            rsp_bus.ready <= ($urandom_range(0, 9) < 6);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      solution_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         recv_count++;
         if (expected_q.size() == 0) begin
            $error("unexpected transaction on rsp_bus");
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (want.singular)
               singular_count++;
            if (want.saturated)
               clip_count++;
            if (rsp_bus.sol_x !== want.x) begin
               $error("sol_x expected %0d actual %0d", want.x, rsp_bus.sol_x);
               error_count++;
            end
            if (rsp_bus.sol_y !== want.y) begin
               $error("sol_y expected %0d actual %0d", want.y, rsp_bus.sol_y);
               error_count++;
            end
            if (rsp_bus.sol_z !== want.z) begin
               $error("sol_z expected %0d actual %0d", want.z, rsp_bus.sol_z);
               error_count++;
            end
            if (rsp_bus.singular !== want.singular) begin
               $error("singular expected %0d actual %0d", want.singular, rsp_bus.singular);
               error_count++;
            end
            if (rsp_bus.saturated !== want.saturated) begin
               $error("saturated expected %0d actual %0d", want.saturated, rsp_bus.saturated);
               error_count++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Solved %0d systems (%0d sent): %0d singular, %0d with clipped solutions.",
               recv_count, sent_count, singular_count, clip_count);
      if (error_count == 0 && expected_q.size() == 0)
         $display("cramer_3x3_linear_solver_unit: match");
      else
         $display("cramer_3x3_linear_solver_unit: mismatch");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d transactions outstanding.", expected_q.size());
      $display("cramer_3x3_linear_solver_unit: mismatch");
      $finish;
   end

endmodule
